// File: rtl/eabv_pkg.sv
// ----------------------------------------------------------------------------
// eabv_pkg
// Shared types, constants, sine table generator and the product sequence
// for the Euler-angle to basis-vector unit.
// ----------------------------------------------------------------------------
package eabv_pkg;

	localparam int ANGLE_BITS         = 16;
	localparam int FRAC_BITS          = 14;
	localparam int SINE_TABLE_ENTRIES = 256;

	localparam int FIELD_BITS    = 16;
	localparam int QUARTER_SHIFT = ANGLE_BITS - 2;
	localparam int VAL_BITS      = FRAC_BITS + 2;
	localparam int ONE_BITS      = FRAC_BITS + 1;
	localparam int PROD_BITS     = 2 * VAL_BITS;
	localparam int IDX_BITS      = $clog2(SINE_TABLE_ENTRIES + 1);
	localparam int IDX_PROD_BITS = QUARTER_SHIFT + IDX_BITS;
	localparam int EXT_BITS      = (ANGLE_BITS > FIELD_BITS) ? ANGLE_BITS : FIELD_BITS;
	localparam int OUT_EXT_BITS  = (VAL_BITS > FIELD_BITS) ? VAL_BITS : FIELD_BITS;
	localparam int unsigned HALF_STEP = (1 << QUARTER_SHIFT) >> 1;

	localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = {2'b01, {QUARTER_SHIFT{1'b0}}};
	localparam logic signed [VAL_BITS-1:0] ONE_VAL = {2'b01, {FRAC_BITS{1'b0}}};
	localparam logic signed [VAL_BITS-1:0] MINUS_ONE_VAL = -ONE_VAL;

	localparam logic [63:0] HALF_PI_Q30 = 64'h6487_ED51;
	localparam int TAYLOR_TERMS = 12;
	localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	localparam int LOOKUP_STEPS = 6;
	localparam int MAC_STEPS    = 15;
	localparam int STEP_BITS    = $clog2(MAC_STEPS);
	localparam logic [STEP_BITS-1:0] LOOKUP_LAST = STEP_BITS'(LOOKUP_STEPS - 1);
	localparam logic [STEP_BITS-1:0] MAC_LAST    = STEP_BITS'(MAC_STEPS - 1);

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] delta_yaw;
		logic signed [FIELD_BITS-1:0] delta_pitch;
		logic signed [FIELD_BITS-1:0] delta_roll;
	} delta_t;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] front_x;
		logic signed [FIELD_BITS-1:0] front_y;
		logic signed [FIELD_BITS-1:0] front_z;
		logic signed [FIELD_BITS-1:0] side_x;
		logic signed [FIELD_BITS-1:0] side_y;
		logic signed [FIELD_BITS-1:0] side_z;
		logic signed [FIELD_BITS-1:0] up_x;
		logic signed [FIELD_BITS-1:0] up_y;
		logic signed [FIELD_BITS-1:0] up_z;
	} basis_t;

	typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_MAC, ST_DONE} state_t;

	typedef enum logic [1:0] {OP_MOV, OP_ADD, OP_SUB, OP_NEG} mac_op_t;

	typedef enum logic [3:0] {
		SRC_A, SRC_B, SRC_C, SRC_D, SRC_E, SRC_F, SRC_CA, SRC_DA, SRC_ONE
	} src_t;

	typedef enum logic [3:0] {
		DST_CA, DST_DA, DST_FX, DST_FY, DST_FZ, DST_SX, DST_SY, DST_SZ,
		DST_UX, DST_UY, DST_UZ
	} dst_t;

	typedef struct packed {
		src_t    src_x;
		src_t    src_y;
		dst_t    dst;
		mac_op_t op;
	} ucode_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] angle;
		logic                  cosine;
	} sine_req_t;

	// a = sin pitch, b = cos pitch, c = sin yaw, d = cos yaw, e = sin roll, f = cos roll
	function automatic ucode_t ucode(input logic [STEP_BITS-1:0] step);
		ucode_t uc;
		unique case (step)
			4'd0:    uc = '{SRC_C,  SRC_B,   DST_FX, OP_MOV};
			4'd1:    uc = '{SRC_B,  SRC_D,   DST_FZ, OP_MOV};
			4'd2:    uc = '{SRC_C,  SRC_A,   DST_CA, OP_MOV};
			4'd3:    uc = '{SRC_D,  SRC_A,   DST_DA, OP_MOV};
			4'd4:    uc = '{SRC_D,  SRC_F,   DST_SX, OP_MOV};
			4'd5:    uc = '{SRC_CA, SRC_E,   DST_SX, OP_ADD};
			4'd6:    uc = '{SRC_E,  SRC_B,   DST_SY, OP_MOV};
			4'd7:    uc = '{SRC_DA, SRC_E,   DST_SZ, OP_MOV};
			4'd8:    uc = '{SRC_C,  SRC_F,   DST_SZ, OP_SUB};
			4'd9:    uc = '{SRC_CA, SRC_F,   DST_UX, OP_MOV};
			4'd10:   uc = '{SRC_D,  SRC_E,   DST_UX, OP_SUB};
			4'd11:   uc = '{SRC_F,  SRC_B,   DST_UY, OP_MOV};
			4'd12:   uc = '{SRC_C,  SRC_E,   DST_UZ, OP_MOV};
			4'd13:   uc = '{SRC_DA, SRC_F,   DST_UZ, OP_ADD};
			4'd14:   uc = '{SRC_A,  SRC_ONE, DST_FY, OP_NEG};
			default: uc = '{SRC_ONE, SRC_ONE, DST_FY, OP_MOV};
		endcase
		return uc;
	endfunction

	// Quarter-wave sine entry, Taylor series in unsigned Q30, evaluated at elaboration
	function automatic logic [ONE_BITS-1:0] sine_entry(input int unsigned i);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_ENTRIES;
		term = x;
		sum  = x;
		for (int k = 0; k < TAYLOR_TERMS; k++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / TAYLOR_DIV[k];
			if (k[0] == 1'b0)
				sum = sum - term;
			else
				sum = sum + term;
		end
		v = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
		if (v > 64'(ONE_VAL))
			v = 64'(ONE_VAL);
		return v[ONE_BITS-1:0];
	endfunction

	function automatic logic [ANGLE_BITS-1:0] angle_add(input logic [ANGLE_BITS-1:0] angle,
			input logic signed [FIELD_BITS-1:0] delta);
		logic signed [EXT_BITS-1:0] ext;
		ext = EXT_BITS'(delta);
		return angle + ANGLE_BITS'(ext);
	endfunction

	function automatic logic signed [FIELD_BITS-1:0] to_field(
			input logic signed [VAL_BITS-1:0] v);
		logic signed [OUT_EXT_BITS-1:0] ext;
		ext = OUT_EXT_BITS'(v);
		return ext[FIELD_BITS-1:0];
	endfunction

endpackage

// File: rtl/eabv_sine.sv
// ----------------------------------------------------------------------------
// eabv_sine
// Sine/cosine lookup: quadrant fold of a binary angle onto a quarter-wave ROM.
// ----------------------------------------------------------------------------
module eabv_sine import eabv_pkg::*; (
	input  sine_req_t                   req,
	output logic signed [VAL_BITS-1:0]  value
);

	logic [ONE_BITS-1:0] sine_rom [SINE_TABLE_ENTRIES+1];

	for (genvar g = 0; g <= SINE_TABLE_ENTRIES; g++) begin : g_rom
		localparam logic [ONE_BITS-1:0] ENTRY = sine_entry(g);
		assign sine_rom[g] = ENTRY;
	end

	logic [ANGLE_BITS-1:0]    ang;
	logic [1:0]               quad;
	logic [QUARTER_SHIFT-1:0] phase;
	logic [IDX_PROD_BITS-1:0] scaled;
	logic [IDX_BITS-1:0]      idx;
	logic signed [VAL_BITS-1:0] mag;

	always_comb begin
		ang    = req.angle + (req.cosine ? QUARTER_TURN : '0);
		quad   = ang[ANGLE_BITS-1 -: 2];
		phase  = ang[QUARTER_SHIFT-1:0];
		scaled = (IDX_PROD_BITS'(phase) * IDX_PROD_BITS'(SINE_TABLE_ENTRIES)
			+ IDX_PROD_BITS'(HALF_STEP)) >> QUARTER_SHIFT;
		if (scaled > IDX_PROD_BITS'(SINE_TABLE_ENTRIES))
			idx = IDX_BITS'(SINE_TABLE_ENTRIES);
		else
			idx = scaled[IDX_BITS-1:0];
		if (quad[0])
			idx = IDX_BITS'(SINE_TABLE_ENTRIES) - idx;
		mag   = VAL_BITS'(sine_rom[idx]);
		value = quad[1] ? -mag : mag;
	end

endmodule

// File: rtl/eabv_mac.sv
// ----------------------------------------------------------------------------
// eabv_mac
// Shared fixed-point multiply, round-to-nearest, saturate and accumulate.
// ----------------------------------------------------------------------------
module eabv_mac import eabv_pkg::*; (
	input  mac_op_t                     op,
	input  logic signed [VAL_BITS-1:0]  x,
	input  logic signed [VAL_BITS-1:0]  y,
	input  logic signed [VAL_BITS-1:0]  acc,
	output logic signed [VAL_BITS-1:0]  result
);

	logic signed [PROD_BITS-1:0] prod;
	logic signed [PROD_BITS-1:0] shifted;
	logic signed [VAL_BITS-1:0]  prod_sat;
	logic signed [VAL_BITS-1:0]  base;
	logic signed [VAL_BITS:0]    sum;

	always_comb begin
		prod    = PROD_BITS'(x) * PROD_BITS'(y);
		shifted = (prod + (PROD_BITS'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (shifted > PROD_BITS'(ONE_VAL))
			prod_sat = ONE_VAL;
		else if (shifted < PROD_BITS'(MINUS_ONE_VAL))
			prod_sat = MINUS_ONE_VAL;
		else
			prod_sat = shifted[VAL_BITS-1:0];

		unique case (op)
			OP_ADD, OP_SUB: base = acc;
			default:        base = '0;
		endcase

		unique case (op)
			OP_SUB, OP_NEG: sum = (VAL_BITS+1)'(base) - (VAL_BITS+1)'(prod_sat);
			default:        sum = (VAL_BITS+1)'(base) + (VAL_BITS+1)'(prod_sat);
		endcase

		if (sum > (VAL_BITS+1)'(ONE_VAL))
			result = ONE_VAL;
		else if (sum < (VAL_BITS+1)'(MINUS_ONE_VAL))
			result = MINUS_ONE_VAL;
		else
			result = sum[VAL_BITS-1:0];
	end

endmodule

// File: rtl/euler_angles_to_basis_vectors_unit.sv
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors_unit
// Each delta beat adds yaw, pitch and roll increments to three wrapping angle
// registers, then returns the camera front, side and up unit vectors as nine
// Q2.14 components in one basis beat. Each item first uses the single sine ROM
// port (sin and cos of each angle), then the single multiply-accumulate unit
// (one product per cycle), then loads the output register and returns to idle,
// where delta_ready is high again. A finished basis beat waits in its own
// register, so the next delta beat may be accepted before it is taken; the
// unit stalls in its last step only if the previous result is still unclaimed.
// ----------------------------------------------------------------------------
module euler_angles_to_basis_vectors_unit import eabv_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   delta_valid,
	output logic   delta_ready,
	input  delta_t delta,
	output logic   basis_valid,
	input  logic   basis_ready,
	output basis_t basis
);

	state_t state_q, state_d;
	logic [STEP_BITS-1:0] step_q, step_d;
	logic [ANGLE_BITS-1:0] yaw_q, pitch_q, roll_q;
	logic basis_valid_q;
	basis_t basis_q;

	logic signed [VAL_BITS-1:0] a_q, b_q, c_q, d_q, e_q, f_q, ca_q, da_q;
	logic signed [VAL_BITS-1:0] fx_q, fy_q, fz_q, sx_q, sy_q, sz_q, ux_q, uy_q, uz_q;

	logic accept, lookup_we, mac_we, load_out;
	ucode_t uc;
	sine_req_t sine_req;
	logic signed [VAL_BITS-1:0] sine_val;
	logic signed [VAL_BITS-1:0] op_x, op_y, op_acc, mac_res;

	assign accept      = delta_valid && delta_ready;
	assign delta_ready = (state_q == ST_IDLE);
	assign basis_valid = basis_valid_q;
	assign basis       = basis_q;
	assign uc          = ucode(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		lookup_we = 1'b0;
		mac_we    = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOKUP;
					step_d  = '0;
				end
			end
			ST_LOOKUP: begin
				lookup_we = 1'b1;
				if (step_q == LOOKUP_LAST) begin
					state_d = ST_MAC;
					step_d  = '0;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_MAC: begin
				mac_we = 1'b1;
				if (step_q == MAC_LAST) begin
					state_d = ST_DONE;
					step_d  = '0;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (!basis_valid_q || basis_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q   <= '0;
			pitch_q <= '0;
			roll_q  <= '0;
		end else if (accept) begin
			yaw_q   <= angle_add(yaw_q, delta.delta_yaw);
			pitch_q <= angle_add(pitch_q, delta.delta_pitch);
			roll_q  <= angle_add(roll_q, delta.delta_roll);
		end
	end

	// lookup order: sin/cos pitch, sin/cos yaw, sin/cos roll
	always_comb begin
		sine_req.cosine = step_q[0];
		case (step_q)
			4'd0, 4'd1: sine_req.angle = pitch_q;
			4'd2, 4'd3: sine_req.angle = yaw_q;
			default:    sine_req.angle = roll_q;
		endcase
	end

	eabv_sine u_sine (
		.req   (sine_req),
		.value (sine_val)
	);

	always_comb begin
		case (uc.src_x)
			SRC_A:   op_x = a_q;
			SRC_B:   op_x = b_q;
			SRC_C:   op_x = c_q;
			SRC_D:   op_x = d_q;
			SRC_E:   op_x = e_q;
			SRC_F:   op_x = f_q;
			SRC_CA:  op_x = ca_q;
			SRC_DA:  op_x = da_q;
			default: op_x = ONE_VAL;
		endcase
		case (uc.src_y)
			SRC_A:   op_y = a_q;
			SRC_B:   op_y = b_q;
			SRC_C:   op_y = c_q;
			SRC_D:   op_y = d_q;
			SRC_E:   op_y = e_q;
			SRC_F:   op_y = f_q;
			SRC_CA:  op_y = ca_q;
			SRC_DA:  op_y = da_q;
			default: op_y = ONE_VAL;
		endcase
		case (uc.dst)
			DST_SX:  op_acc = sx_q;
			DST_SZ:  op_acc = sz_q;
			DST_UX:  op_acc = ux_q;
			DST_UZ:  op_acc = uz_q;
			default: op_acc = '0;
		endcase
	end

	eabv_mac u_mac (
		.op     (uc.op),
		.x      (op_x),
		.y      (op_y),
		.acc    (op_acc),
		.result (mac_res)
	);

	always_ff @(posedge clk) begin
		if (lookup_we) begin
			case (step_q)
				4'd0:    a_q <= sine_val;
				4'd1:    b_q <= sine_val;
				4'd2:    c_q <= sine_val;
				4'd3:    d_q <= sine_val;
				4'd4:    e_q <= sine_val;
				default: f_q <= sine_val;
			endcase
		end
		if (mac_we) begin
			unique case (uc.dst)
				DST_CA:  ca_q <= mac_res;
				DST_DA:  da_q <= mac_res;
				DST_FX:  fx_q <= mac_res;
				DST_FY:  fy_q <= mac_res;
				DST_FZ:  fz_q <= mac_res;
				DST_SX:  sx_q <= mac_res;
				DST_SY:  sy_q <= mac_res;
				DST_SZ:  sz_q <= mac_res;
				DST_UX:  ux_q <= mac_res;
				DST_UY:  uy_q <= mac_res;
				DST_UZ:  uz_q <= mac_res;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			basis_q.front_x <= to_field(fx_q);
			basis_q.front_y <= to_field(fy_q);
			basis_q.front_z <= to_field(fz_q);
			basis_q.side_x  <= to_field(sx_q);
			basis_q.side_y  <= to_field(sy_q);
			basis_q.side_z  <= to_field(sz_q);
			basis_q.up_x    <= to_field(ux_q);
			basis_q.up_y    <= to_field(uy_q);
			basis_q.up_z    <= to_field(uz_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_valid_q <= 1'b0;
		end else if (load_out) begin
			basis_valid_q <= 1'b1;
		end else if (basis_ready) begin
			basis_valid_q <= 1'b0;
		end
	end

	a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOOKUP) && (step_q == '0))
		else $error("accepted beat did not start the lookup phase");

	a_angles_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(yaw_q) && $stable(pitch_q) && $stable(roll_q))
		else $error("angle registers changed without a delta beat");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(basis_valid) |-> $past(state_q == ST_DONE))
		else $error("basis beat raised outside the final step");

	a_front_y_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (fy_q == -a_q))
		else $error("front_y is not the negated pitch sine");

	a_mac_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (step_q <= MAC_LAST))
		else $error("product sequencer stepped past its last step");

endmodule
